// File: hw/rtl/u8u16_pkg.sv
// u8u16_pkg: types and constants shared by the UTF-8 to UTF-16 transcoder.
// No dependencies; imported by every module of the block.
package u8u16_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CP_W    = 21;
    localparam int unsigned UNIT_W  = 16;
    localparam int unsigned OTDATA_W = 24;   // code_unit, stopped_early, zero fill
    localparam int unsigned OTUSER_W = 2;    // unit_valid, string_end

    localparam logic [CP_W-1:0]   CP_SUPP_BASE = 21'h10000;
    localparam logic [UNIT_W-1:0] HI_SURR_BASE = 16'hD800;
    localparam logic [UNIT_W-1:0] LO_SURR_BASE = 16'hDC00;

    // One decoded byte's worth of work for the back end
    typedef struct packed {
        logic            has_cp;    // a complete code point is to be written out
        logic            is_pair;   // that code point needs a surrogate pair
        logic [CP_W-1:0] cp;
        logic            has_end;   // end-of-string marker follows
        logic            stopped;   // stopped flag for the end marker
    } job_t;

endpackage

// File: hw/rtl/u8u16_front.sv
// u8u16_front: accepts UTF-8 bytes, tracks the sequence state, builds jobs.
// Depends on u8u16_pkg.
module u8u16_front
    import u8u16_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_fire,
    input  logic [BYTE_W-1:0] text_byte,
    input  logic              string_last,
    output logic              job_push,
    output job_t              job
);

    logic [1:0]      pend_reg, pend_next;
    logic [CP_W-1:0] part_reg, part_next;
    logic            halt_reg, halt_next;
    logic            emit;
    logic [CP_W-1:0] emit_cp;

    always_comb
    begin
        pend_next = pend_reg;
        part_next = part_reg;
        halt_next = halt_reg;
        emit      = 1'b0;
        emit_cp   = '0;
        if (!halt_reg) begin
            if (pend_reg == 2'd0) begin
                if (text_byte[7] == 1'b0) begin
                    emit    = 1'b1;
                    emit_cp = {{(CP_W-BYTE_W){1'b0}}, text_byte};
                end else if (text_byte[7:5] == 3'b110) begin
                    part_next = {{(CP_W-5){1'b0}}, text_byte[4:0]};
                    pend_next = 2'd1;
                end else if (text_byte[7:4] == 4'b1110) begin
                    part_next = {{(CP_W-4){1'b0}}, text_byte[3:0]};
                    pend_next = 2'd2;
                end else if (text_byte[7:3] == 5'b11110) begin
                    part_next = {{(CP_W-3){1'b0}}, text_byte[2:0]};
                    pend_next = 2'd3;
                end else begin
                    halt_next = 1'b1;
                end
            end else if (text_byte[7:6] != 2'b10) begin
                halt_next = 1'b1;
            end else begin
                part_next = {part_reg[CP_W-7:0], text_byte[5:0]};
                pend_next = pend_reg - 2'd1;
                if (pend_next == 2'd0) begin
                    emit    = 1'b1;
                    emit_cp = part_next;
                end
            end
        end

        job.has_cp  = emit;
        job.cp      = emit_cp;
        job.is_pair = (emit_cp >= CP_SUPP_BASE);
        job.has_end = string_last;
        job.stopped = halt_next | (pend_next != 2'd0);
        job_push    = byte_fire & (emit | string_last);

        // a string's end clears everything for the next one
        if (string_last) begin
            pend_next = 2'd0;
            part_next = '0;
            halt_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pend_reg <= 2'd0;
            part_reg <= '0;
            halt_reg <= 1'b0;
        end else if (byte_fire) begin
            pend_reg <= pend_next;
            part_reg <= part_next;
            halt_reg <= halt_next;
        end
    end

endmodule

// File: hw/rtl/u8u16_queue.sv
// u8u16_queue: small job queue decoupling the byte decoder from the unit writer.
// Depends on u8u16_pkg.
module u8u16_queue
    import u8u16_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic not_full,
    input  logic pop,
    output job_t pop_job,
    output logic not_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_push, do_pop;

    assign not_full  = (cnt_reg != FULL_CNT);
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push & not_full;
    assign do_pop    = pop & not_empty;
    assign pop_job   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: hw/rtl/u8u16_back.sv
// u8u16_back: expands jobs into UTF-16 units and end markers, one word a cycle unless stalled.
// Depends on u8u16_pkg.
module u8u16_back
    import u8u16_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_avail,
    input  job_t                job,
    output logic                job_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                unit_valid,
    output logic [UNIT_W-1:0]   code_unit,
    output logic                string_end,
    output logic                stopped_early,
    output logic                run_last
);

    job_t            cur_reg;
    logic            cur_valid_reg;
    logic [1:0]      step_reg;
    logic            out_valid_reg;
    logic            uv_reg, end_reg, stop_reg, last_reg;
    logic [UNIT_W-1:0] unit_reg;

    logic [1:0]      n_units, n_total;
    logic            last_step, load_out, job_done;
    logic [CP_W-1:0] cp_off;
    logic            r_uv, r_end, r_stop;
    logic [UNIT_W-1:0] r_unit;

    always_comb
    begin
        n_units   = cur_reg.has_cp ? (cur_reg.is_pair ? 2'd2 : 2'd1) : 2'd0;
        n_total   = n_units + {1'b0, cur_reg.has_end};
        last_step = (step_reg == n_total - 2'd1);
        cp_off    = cur_reg.cp - CP_SUPP_BASE;
        if (step_reg < n_units) begin
            r_uv   = 1'b1;
            r_end  = 1'b0;
            r_stop = 1'b0;
            if (!cur_reg.is_pair) begin
                r_unit = cur_reg.cp[UNIT_W-1:0];
            end else if (step_reg == 2'd0) begin
                r_unit = HI_SURR_BASE + {5'd0, cp_off[CP_W-1:10]};
            end else begin
                r_unit = LO_SURR_BASE | {6'd0, cp_off[9:0]};
            end
        end else begin
            r_uv   = 1'b0;
            r_end  = 1'b1;
            r_stop = cur_reg.stopped;
            r_unit = '0;
        end
    end

    assign load_out = cur_valid_reg & (~out_valid_reg | out_ready);
    assign job_done = load_out & last_step;
    assign job_pop  = job_avail & (~cur_valid_reg | job_done);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cur_valid_reg <= 1'b0;
            step_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (job_pop) begin
                cur_valid_reg <= 1'b1;
                step_reg      <= 2'd0;
            end else if (job_done) begin
                cur_valid_reg <= 1'b0;
            end else if (load_out) begin
                step_reg <= step_reg + 2'd1;
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop) begin
            cur_reg <= job;
        end
        if (load_out) begin
            uv_reg   <= r_uv;
            unit_reg <= r_unit;
            end_reg  <= r_end;
            stop_reg <= r_stop;
            last_reg <= last_step;
        end
    end

    assign out_valid     = out_valid_reg;
    assign unit_valid    = uv_reg;
    assign code_unit     = unit_reg;
    assign string_end    = end_reg;
    assign stopped_early = stop_reg;
    assign run_last      = last_reg;

endmodule

// File: hw/rtl/utf8_to_utf16_transcoder_unit.sv
// utf8_to_utf16_transcoder_unit: top level of the UTF-8 to UTF-16 transcoder.
// Depends on u8u16_pkg, u8u16_front, u8u16_queue, u8u16_back.
//
// Usage
//   s_axis: one UTF-8 byte per word in tdata[7:0]; tlast marks a string's last byte.
//   m_axis: one result per word. tdata[15:0] code_unit, tdata[16] stopped_early;
//   tuser[0] unit_valid, tuser[1] string_end; tlast marks the last word that
//   one input byte gives rise to.
//   Each complete code point gives one unit, or a high then a low surrogate
//   for 0x10000 and above. A string's last byte adds an end marker word whose
//   stopped_early says an invalid or truncated sequence halted the conversion;
//   bytes after a halt give nothing until that end marker.
// Timing
//   Input takes one byte per cycle while the queue has room. A byte's first word
//   reaches m_axis through the queue, then the job register, then the output
//   register. The writer sends one word per cycle while m_axis_tready is high,
//   so a burst of bytes giving two or three words each is paced by the writer;
//   the job queue (QUEUE_DEPTH entries) absorbs it and tready falls only when it fills.
// Reset and stalls
//   rst_n clears the sequence state, the queue and the output valid at once.
//   When m_axis_tready is low the output word holds, the writer waits and
//   bytes keep flowing in until the queue is full.
module utf8_to_utf16_transcoder_unit
    import u8u16_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [BYTE_W-1:0]    s_axis_tdata,   // [7:0] text_byte
    input  logic                 s_axis_tlast,   // string_last
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OTDATA_W-1:0]  m_axis_tdata,   // [15:0] code_unit, [16] stopped_early, zero
    output logic [OTUSER_W-1:0]  m_axis_tuser,   // [0] unit_valid, [1] string_end
    output logic                 m_axis_tlast    // run_last
);

    logic              byte_fire;
    logic              job_push, q_not_full, q_not_empty, job_pop;
    job_t              front_job, q_job;
    logic              unit_valid, string_end, stopped_early;
    logic [UNIT_W-1:0] code_unit;

    // a byte is only taken when its job is sure to fit
    assign s_axis_tready = q_not_full;
    assign byte_fire     = s_axis_tvalid & q_not_full;

    u8u16_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_fire   (byte_fire),
        .text_byte   (s_axis_tdata),
        .string_last (s_axis_tlast),
        .job_push    (job_push),
        .job         (front_job)
    );

    u8u16_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_job  (front_job),
        .not_full  (q_not_full),
        .pop       (job_pop),
        .pop_job   (q_job),
        .not_empty (q_not_empty)
    );

    u8u16_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_avail     (q_not_empty),
        .job           (q_job),
        .job_pop       (job_pop),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .unit_valid    (unit_valid),
        .code_unit     (code_unit),
        .string_end    (string_end),
        .stopped_early (stopped_early),
        .run_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {{(OTDATA_W-UNIT_W-1){1'b0}}, stopped_early, code_unit};
    assign m_axis_tuser = {string_end, unit_valid};

endmodule

// File: hw/rtl/u8u16_checker.sv
// u8u16_props: port-level checks on the transcoder's output stream, and its bind.
// Depends on u8u16_pkg and utf8_to_utf16_transcoder_unit.
module u8u16_props
    import u8u16_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [OTDATA_W-1:0] m_axis_tdata,
    input  logic [OTUSER_W-1:0] m_axis_tuser,
    input  logic                m_axis_tlast
);

    // a stalled word holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    // the end marker is always the final word of its byte
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
        else $error("end marker without tlast");

    // end marker carries no unit
    a_end_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
            !m_axis_tuser[0] && (m_axis_tdata[UNIT_W-1:0] == '0))
        else $error("end marker carries a unit");

    // unit words never report a stop
    a_unit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tdata[UNIT_W] && !m_axis_tuser[1])
        else $error("unit word with stop or end flag");

endmodule

bind utf8_to_utf16_transcoder_unit u8u16_props u_u8u16_props (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
